/* rtl/core/b64_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, constants and the character map of the Base64 encoder.
// ----------------------------------------------------------------------------
package b64_pkg;

  // Padding character and the number of characters one group expands to.
  localparam logic [7:0] PAD_CHAR      = 8'h3d;
  localparam int         CHARS_PER_GRP = 4;

  // One group of up to three bytes waiting for the character stage.
  typedef struct packed {
    logic [23:0] group;   // first byte in bits 23..16, missing bytes zero
    logic [1:0]  nbytes;  // number of real bytes in the group, 1 to 3
    logic        last;    // group ends the message
  } grp_entry_t;

  // Map one 6-bit value to its character of the standard alphabet.
  function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
    logic [7:0] ext;
    ext = {2'b00, v};
    if (v < 6'd26) begin
      return ext + 8'd65;           // 'A'..'Z'
    end else if (v < 6'd52) begin
      return ext + 8'd71;           // 'a'..'z'
    end else if (v < 6'd62) begin
      return ext - 8'd4;            // '0'..'9'
    end else if (v == 6'd62) begin
      return 8'h2b;                 // '+'
    end else begin
      return 8'h2f;                 // '/'
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/core/b64_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// b64_front
// Accepts input bytes, collects them into groups of three and hands each
// complete or final group to the queue.
// ----------------------------------------------------------------------------
module b64_front import b64_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic       s_tlast,   // last_byte
  input  wire logic       q_full,
  output logic            q_push,
  output grp_entry_t      q_entry
);

  logic [15:0] pend_bytes;
  logic [15:0] pend_bytes_next;
  logic [1:0]  pend_count;
  logic [1:0]  pend_count_next;
  logic        accept;

  // A beat is taken whenever the queue has room for a possible group.
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  // Classify the beat: finish a group, or hold the byte.
  always_comb begin
    pend_bytes_next = pend_bytes;
    pend_count_next = pend_count;
    q_push          = 1'b0;
    q_entry.group   = {pend_bytes, s_tdata};
    q_entry.nbytes  = 2'd3;
    q_entry.last    = s_tlast;
    if (pend_count >= 2'd2) begin
      q_entry.group  = {pend_bytes, s_tdata};
      q_entry.nbytes = 2'd3;
    end else if (pend_count == 2'd1) begin
      q_entry.group  = {pend_bytes[15:8], s_tdata, 8'h00};
      q_entry.nbytes = 2'd2;
    end else begin
      q_entry.group  = {s_tdata, 16'h0000};
      q_entry.nbytes = 2'd1;
    end
    if (accept) begin
      if (pend_count >= 2'd2 || s_tlast) begin
        q_push          = 1'b1;
        pend_bytes_next = 16'h0000;
        pend_count_next = 2'd0;
      end else if (pend_count == 2'd0) begin
        pend_bytes_next = {s_tdata, 8'h00};
        pend_count_next = 2'd1;
      end else begin
        pend_bytes_next = {pend_bytes[15:8], s_tdata};
        pend_count_next = 2'd2;
      end
    end
  end

  // Pending bytes and their count.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_count <= 2'd0;
      pend_bytes <= 16'h0000;
    end else begin
      pend_count <= pend_count_next;
      pend_bytes <= pend_bytes_next;
    end
  end

  // The count never reaches three.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    pend_count != 2'd3)
    else $error("front pending count reached three");

  // Holding the first byte of a group, when it is not the last byte, never pushes a group.
  a_hold_no_push: assert property (@(posedge clk) disable iff (rst)
    (accept && pend_count == 2'd0 && !s_tlast) |-> !q_push)
    else $error("front pushed a group on a held byte");

  // After a push the next group starts empty.
  a_push_clears: assert property (@(posedge clk) disable iff (rst)
    q_push |=> pend_count == 2'd0)
    else $error("front kept bytes after a push");

endmodule
`default_nettype wire

/* rtl/core/b64_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// b64_queue
// Short first-in first-out queue of groups between the front and back parts.
// ----------------------------------------------------------------------------
module b64_queue import b64_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  grp_entry_t      push_entry,
  output logic            full,
  input  wire logic       pop,
  output grp_entry_t      head,
  output logic            empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  grp_entry_t         slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/b64_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// b64_back
// Takes one group at a time from the queue and sends its four characters,
// one a cycle unless the output stalls, through a registered output stage.
// ----------------------------------------------------------------------------
module b64_back import b64_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  grp_entry_t      q_head,
  input  wire logic       q_empty,
  output logic            q_pop,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_char
  output logic            m_tlast    // last_char
);

  localparam logic [1:0] LAST_SLOT = 2'(CHARS_PER_GRP - 1);

  grp_entry_t  cur;
  logic        cur_valid;
  logic [1:0]  slot;
  logic        out_free;
  logic        emit;
  logic [5:0]  sextet;
  logic [7:0]  char_val;

  // The output register can load when it is empty or being drained.
  assign out_free = !m_tvalid || m_tready;
  assign emit     = cur_valid && out_free;
  assign q_pop    = !q_empty && (!cur_valid || (emit && slot == LAST_SLOT));

  // Pick the slice of the group for this slot and map it.
  always_comb begin
    case (slot)
      2'd0:    sextet = cur.group[23:18];
      2'd1:    sextet = cur.group[17:12];
      2'd2:    sextet = cur.group[11:6];
      default: sextet = cur.group[5:0];
    endcase
    char_val = (slot <= cur.nbytes) ? sextet_to_char(sextet) : PAD_CHAR;
  end

  // Current group and character counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      slot      <= 2'd0;
    end else begin
      if (emit) begin
        slot <= slot + 1'b1;
        if (slot == LAST_SLOT) begin
          cur_valid <= 1'b0;
        end
      end
      if (q_pop) begin
        cur_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= char_val;
      m_tlast <= cur.last && (slot == LAST_SLOT);
    end
  end

  // With no group loaded the counter rests at the first slot.
  a_idle_slot: assert property (@(posedge clk) disable iff (rst)
    !cur_valid |-> slot == 2'd0)
    else $error("back counter moved without a group");

  // A stalled output holds the character counter.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(slot))
    else $error("back advanced during an output stall");

  // Every loaded group holds at least one real byte.
  a_group_bytes: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> cur.nbytes != 2'd0)
    else $error("back loaded a group with no bytes");

endmodule
`default_nettype wire

/* rtl/core/base64_encoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// base64_encoder
// Streaming Base64 encoder, standard alphabet, padded with '='.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one message byte per beat; s_tlast marks the
//   final byte. The master channel sends one ASCII character per beat;
//   m_tlast marks the final character of the encoded message.
//   Every third byte, and the final byte, closes a group. The group is
//   handed through a short queue to the character stage, which sends four
//   characters, padding a short final group with '='.
//   Throughput: the character stage sends one character per cycle while
//   the receiver is ready, so on a long message the output side is the
//   limit. The queue of QUEUE_DEPTH groups lets bytes keep arriving
//   while a group is being sent.
//   Reset (rst, synchronous) drops any held bytes and queued groups and
//   clears m_tvalid. When the receiver stalls, the output character holds,
//   the queue fills and s_tready falls once it is full.
// ----------------------------------------------------------------------------
module base64_encoder import b64_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic       s_tlast,   // last_byte
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_char
  output logic            m_tlast    // last_char
);

  grp_entry_t push_entry;
  grp_entry_t head;
  logic       push;
  logic       pop;
  logic       full;
  logic       empty;

  b64_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (full),
    .q_push   (push),
    .q_entry  (push_entry)
  );

  b64_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .empty      (empty)
  );

  b64_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_head   (head),
    .q_empty  (empty),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire
